// File: design/implicit_list_heap_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator_unit_defines
// assertion macros used by the top-level allocator design file
// ----------------------------------------------------------------------------
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define ILHA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// next-cycle implication under reset
`define ILHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// File: design/ilha_pkg.sv
// ----------------------------------------------------------------------------
// ilha_pkg
// types, constants and sequencer codes of the boundary-tag heap allocator
// ----------------------------------------------------------------------------
`default_nettype none
package ilha_pkg;

    localparam int HEAP_BYTES_DEF = 65536;
    localparam int ADDR_W         = 17;
    localparam int INIT_CHUNK     = 1 << 12;
    localparam int MIN_BLOCK      = 16;
    localparam int HEAP_START     = 8;

    typedef logic [ADDR_W-1:0] addr_t;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // sequencer states, also the command to the datapath
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] S_INIT     = 5'd0;
    localparam logic [OP_W-1:0] S_IDLE     = 5'd1;
    localparam logic [OP_W-1:0] S_FIT_RD   = 5'd2;
    localparam logic [OP_W-1:0] S_FIT_CHK  = 5'd3;
    localparam logic [OP_W-1:0] S_GROW     = 5'd4;
    localparam logic [OP_W-1:0] S_GROW_W2  = 5'd5;
    localparam logic [OP_W-1:0] S_GROW_W3  = 5'd6;
    localparam logic [OP_W-1:0] S_M_RD1    = 5'd7;
    localparam logic [OP_W-1:0] S_M_RD2    = 5'd8;
    localparam logic [OP_W-1:0] S_M_RD3    = 5'd9;
    localparam logic [OP_W-1:0] S_M_CHK    = 5'd10;
    localparam logic [OP_W-1:0] S_M_RD4    = 5'd11;
    localparam logic [OP_W-1:0] S_M_PCHK   = 5'd12;
    localparam logic [OP_W-1:0] S_M_WA     = 5'd13;
    localparam logic [OP_W-1:0] S_M_WB     = 5'd14;
    localparam logic [OP_W-1:0] S_PL_RD    = 5'd15;
    localparam logic [OP_W-1:0] S_PL_CHK   = 5'd16;
    localparam logic [OP_W-1:0] S_PL_W1    = 5'd17;
    localparam logic [OP_W-1:0] S_PL_W2    = 5'd18;
    localparam logic [OP_W-1:0] S_PL_W3    = 5'd19;
    localparam logic [OP_W-1:0] S_PL_W4    = 5'd20;
    localparam logic [OP_W-1:0] S_LIVE_RD  = 5'd21;
    localparam logic [OP_W-1:0] S_LIVE_CHK = 5'd22;
    localparam logic [OP_W-1:0] S_FR_W1    = 5'd23;
    localparam logic [OP_W-1:0] S_FR_W2    = 5'd24;
    localparam logic [OP_W-1:0] S_DONE     = 5'd25;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            accept;
    } ilha_cmd_t;

    typedef struct packed {
        logic init_last;
        logic in_func;
        logic in_zero;
        logic func;
        logic bp_end;
        logic s_zero;
        logic fit_hit;
        logic live_ok;
        logic live_cont;
        logic grow_fail;
        logic prev_used;
        logic next_used;
        logic split;
        logic out_busy;
    } ilha_sts_t;

    // heap word contents after reset
    function automatic logic [31:0] init_word(input logic [15:0] idx, input logic fits);
        logic [31:0] w;
        w = 32'd0;
        case (idx)
            16'd1, 16'd2: w = 32'd9;
            16'd3:        w = fits ? 32'(INIT_CHUNK) : 32'd1;
            16'(2 + INIT_CHUNK / 4): w = fits ? 32'(INIT_CHUNK) : 32'd0;
            16'(3 + INIT_CHUNK / 4): w = fits ? 32'd1 : 32'd0;
            default:      w = 32'd0;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: design/ilha_ctrl.sv
// ----------------------------------------------------------------------------
// ilha_ctrl
// sequencer for init sweep, first-fit walk, grow, merge, place and free
// ----------------------------------------------------------------------------
`default_nettype none
module ilha_ctrl
    import ilha_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire ilha_sts_t sts,
    output ilha_cmd_t      cmd
);

    logic [OP_W-1:0] state_reg;
    logic [OP_W-1:0] state_next;
    logic [OP_W-1:0] ret_state;

    assign in_ready   = (state_reg == S_IDLE);
    assign cmd.op     = state_reg;
    assign cmd.accept = in_valid && in_ready;
    assign ret_state  = (sts.func == FUNC_FREE) ? S_DONE : S_PL_RD;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:     if (sts.init_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (sts.in_zero)
                        state_next = S_DONE;
                    else if (sts.in_func == FUNC_FREE)
                        state_next = S_LIVE_RD;
                    else
                        state_next = S_FIT_RD;
                end
            end
            S_FIT_RD:   state_next = sts.bp_end ? S_GROW : S_FIT_CHK;
            S_FIT_CHK:
            begin
                if (sts.s_zero)
                    state_next = S_GROW;
                else if (sts.fit_hit)
                    state_next = S_PL_RD;
                else
                    state_next = S_FIT_RD;
            end
            S_GROW:     state_next = sts.grow_fail ? S_DONE : S_GROW_W2;
            S_GROW_W2:  state_next = S_GROW_W3;
            S_GROW_W3:  state_next = S_M_RD1;
            S_M_RD1:    state_next = S_M_RD2;
            S_M_RD2:    state_next = S_M_RD3;
            S_M_RD3:    state_next = S_M_CHK;
            S_M_CHK:
            begin
                if (sts.prev_used && sts.next_used)
                    state_next = ret_state;
                else if (sts.prev_used)
                    state_next = S_M_WA;
                else
                    state_next = S_M_RD4;
            end
            S_M_RD4:    state_next = S_M_PCHK;
            S_M_PCHK:   state_next = S_M_WA;
            S_M_WA:     state_next = S_M_WB;
            S_M_WB:     state_next = ret_state;
            S_PL_RD:    state_next = S_PL_CHK;
            S_PL_CHK:   state_next = S_PL_W1;
            S_PL_W1:    state_next = S_PL_W2;
            S_PL_W2:    state_next = sts.split ? S_PL_W3 : S_DONE;
            S_PL_W3:    state_next = S_PL_W4;
            S_PL_W4:    state_next = S_DONE;
            S_LIVE_RD:  state_next = sts.bp_end ? S_DONE : S_LIVE_CHK;
            S_LIVE_CHK:
            begin
                if (sts.live_ok)
                    state_next = S_FR_W1;
                else if (sts.live_cont)
                    state_next = S_LIVE_RD;
                else
                    state_next = S_DONE;
            end
            S_FR_W1:    state_next = S_FR_W2;
            S_FR_W2:    state_next = S_M_RD1;
            S_DONE:     if (!sts.out_busy) state_next = S_IDLE;
            default:    state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

// File: design/ilha_dp.sv
// ----------------------------------------------------------------------------
// ilha_dp
// heap memory, walk pointers, tag arithmetic and the result register
// ----------------------------------------------------------------------------
`default_nettype none
module ilha_dp
    import ilha_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ilha_cmd_t   cmd,
    output ilha_sts_t        sts,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_wdata,
    input  wire logic        func,
    input  wire logic [15:0] request_bytes,
    input  wire logic [15:0] block_addr,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      result_addr,
    output logic [1:0]       status
);

    localparam int CAP_RAW   = (HEAP_BYTES > 65536) ? 65536 : HEAP_BYTES;
    localparam int CAP       = CAP_RAW - (CAP_RAW % 8);
    localparam int DEPTH     = CAP / 4;
    localparam int AW        = $clog2(DEPTH);
    localparam logic FITS    = (CAP >= HEAP_START + 8 + INIT_CHUNK);
    localparam addr_t BRK_RST = FITS ? addr_t'(HEAP_START + 8 + INIT_CHUNK)
                                     : addr_t'(HEAP_START + 8);
    localparam addr_t SZ_MASK = ~addr_t'(7);

    logic [31:0] mem [DEPTH];

    addr_t       bp_reg, size_reg, asize_reg, csize_reg, nsz_reg, brk_reg;
    logic        nused_reg, func_reg, split_reg;
    logic [31:0] ptag_reg, rdata_reg;
    logic [15:0] addr_reg, res_reg;
    logic [1:0]  stat_reg;
    addr_t       chunk_reg;
    logic [AW-1:0] cnt_reg;
    logic        out_valid_reg;
    logic [15:0] result_addr_reg;
    logic [1:0]  status_reg;

    addr_t       rsz, asize_in, ext, psz, rest;
    logic        ralloc;
    logic [17:0] bytes18;
    logic [18:0] brk_sum;
    logic        grow_fail, bp_end, live_hit, live_ok, live_past, live_cont;
    logic        rd_en, wr_en;
    addr_t       rd_addr, wr_addr;
    logic [31:0] wr_data;
    logic [AW-1:0] wr_idx;

    assign rsz      = addr_t'(rdata_reg[ADDR_W-1:0]) & SZ_MASK;
    assign ralloc   = rdata_reg[0];
    assign asize_in = (request_bytes <= 16'd8) ? addr_t'(MIN_BLOCK)
                    : ((addr_t'(request_bytes) + addr_t'(15)) & SZ_MASK);
    assign ext      = (asize_reg > chunk_reg) ? asize_reg : chunk_reg;

    always_comb
    begin
        bytes18 = ({1'b0, ext} + 18'd7) & ~18'd7;
        if (bytes18 < 18'(MIN_BLOCK))
            bytes18 = 18'(MIN_BLOCK);
    end

    assign brk_sum   = {2'b0, brk_reg} + {1'b0, bytes18};
    assign grow_fail = (bytes18 > 18'(CAP)) || (brk_sum > 19'(CAP));
    assign bp_end    = (bp_reg >= brk_reg);
    assign live_hit  = (bp_reg == addr_t'(addr_reg));
    assign live_past = (bp_reg > addr_t'(addr_reg));
    assign live_ok   = (rsz != '0) && live_hit && (bp_reg != addr_t'(HEAP_START)) && ralloc;
    assign live_cont = (rsz != '0) && !live_hit && !live_past;
    assign psz       = split_reg ? asize_reg : csize_reg;
    assign rest      = csize_reg - asize_reg;

    assign sts.init_last = (cnt_reg == AW'(DEPTH - 1));
    assign sts.in_func   = func;
    assign sts.in_zero   = (func == FUNC_FREE) ? (block_addr == '0) : (request_bytes == '0);
    assign sts.func      = func_reg;
    assign sts.bp_end    = bp_end;
    assign sts.s_zero    = (rsz == '0);
    assign sts.fit_hit   = (rsz >= asize_reg) && !ralloc;
    assign sts.live_ok   = live_ok;
    assign sts.live_cont = live_cont;
    assign sts.grow_fail = grow_fail;
    assign sts.prev_used = ptag_reg[0];
    assign sts.next_used = ralloc;
    assign sts.split     = split_reg;
    assign sts.out_busy  = out_valid_reg && !out_ready;

    // one read and one write port per cycle
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = bp_reg - addr_t'(4);
        wr_en   = 1'b0;
        wr_addr = bp_reg - addr_t'(4);
        wr_data = 32'(size_reg);
        case (cmd.op)
            S_FIT_RD, S_LIVE_RD: rd_en = !bp_end;
            S_M_RD1, S_M_RD4, S_PL_RD: rd_en = 1'b1;
            S_M_RD2:
            begin
                rd_en   = 1'b1;
                rd_addr = bp_reg - addr_t'(8);
            end
            S_M_RD3:
            begin
                rd_en   = 1'b1;
                rd_addr = bp_reg + size_reg - addr_t'(4);
            end
            S_GROW:
            begin
                wr_en   = !grow_fail;
                wr_addr = brk_reg - addr_t'(4);
                wr_data = 32'(bytes18);
            end
            S_GROW_W2, S_M_WB, S_FR_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + size_reg - addr_t'(8);
            end
            S_GROW_W3:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + size_reg - addr_t'(4);
                wr_data = 32'd1;
            end
            S_M_WA, S_FR_W1: wr_en = 1'b1;
            S_PL_W1:
            begin
                wr_en   = 1'b1;
                wr_data = 32'(psz) | 32'd1;
            end
            S_PL_W2:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + psz - addr_t'(8);
                wr_data = 32'(psz) | 32'd1;
            end
            S_PL_W3:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + asize_reg - addr_t'(4);
                wr_data = 32'(rest);
            end
            S_PL_W4:
            begin
                wr_en   = 1'b1;
                wr_addr = bp_reg + csize_reg - addr_t'(8);
                wr_data = 32'(rest);
            end
            S_INIT:
            begin
                wr_en   = 1'b1;
                wr_data = init_word(16'(cnt_reg), FITS);
            end
            default: ;
        endcase
    end

    assign wr_idx = (cmd.op == S_INIT) ? cnt_reg : wr_addr[AW+1:2];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr[AW+1:2]];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            brk_reg       <= BRK_RST;
            chunk_reg     <= addr_t'(INIT_CHUNK);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == S_INIT)
                cnt_reg <= cnt_reg + AW'(1);
            if (cfg_we)
                chunk_reg <= cfg_wdata;
            if (cmd.op == S_GROW_W3)
                brk_reg <= bp_reg + size_reg;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.op == S_DONE && !sts.out_busy)
                out_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    func_reg  <= func;
                    addr_reg  <= block_addr;
                    asize_reg <= asize_in;
                    bp_reg    <= addr_t'(HEAP_START);
                    res_reg   <= '0;
                    stat_reg  <= sts.in_zero ? ST_NULL : ST_DONE;
                end
            end
            S_FIT_CHK:
                if (rsz != '0 && !sts.fit_hit) bp_reg <= bp_reg + rsz;
            S_GROW:
            begin
                if (grow_fail)
                    stat_reg <= ST_NOSPACE;
                else
                begin
                    bp_reg   <= brk_reg;
                    size_reg <= addr_t'(bytes18);
                end
            end
            S_M_RD2: size_reg <= rsz;
            S_M_RD3: ptag_reg <= rdata_reg;
            S_M_CHK:
            begin
                if (ptag_reg[0])
                begin
                    if (!ralloc) size_reg <= size_reg + rsz;
                end
                else
                begin
                    // step back over the free previous block
                    bp_reg    <= bp_reg - (addr_t'(ptag_reg[ADDR_W-1:0]) & SZ_MASK);
                    nsz_reg   <= rsz;
                    nused_reg <= ralloc;
                end
            end
            S_M_PCHK: size_reg <= size_reg + rsz + (nused_reg ? addr_t'(0) : nsz_reg);
            S_PL_CHK:
            begin
                csize_reg <= rsz;
                split_reg <= ((rsz - asize_reg) >= addr_t'(MIN_BLOCK));
            end
            S_PL_W2: res_reg <= bp_reg[15:0];
            S_LIVE_RD:
                if (bp_end) stat_reg <= ST_NULL;
            S_LIVE_CHK:
            begin
                if (live_ok)
                    size_reg <= rsz;
                else if (live_cont)
                    bp_reg <= bp_reg + rsz;
                else
                    stat_reg <= ST_NULL;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    result_addr_reg <= res_reg;
                    status_reg      <= stat_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign result_addr = result_addr_reg;
    assign status      = status_reg;

endmodule
`default_nettype wire

// File: design/implicit_list_heap_allocator_unit.sv
// allocate: a first-fit walk over the heap blocks, then grow, merge and split as needed;
//   free walks the heap blocks the same way, then frees and merges
// throughput: one item at a time, set by the tag memory walk (one read and one write port)
// reset: after rst_n the heap memory is swept one word a cycle to lay down
//   prologue, epilogue and the first free chunk;
//   no item is accepted during the sweep, configuration writes are taken
`default_nettype none
`include "implicit_list_heap_allocator_unit_defines.svh"
// ----------------------------------------------------------------------------
// implicit_list_heap_allocator_unit
// first-fit boundary-tag heap allocator with coalescing free
// ----------------------------------------------------------------------------
module implicit_list_heap_allocator_unit
    import ilha_pkg::*;
#(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        func,
    input  wire logic [15:0] request_bytes,
    input  wire logic [15:0] block_addr,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      result_addr,
    output logic [1:0]       status,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_wdata
);

    ilha_cmd_t cmd;
    ilha_sts_t sts;

    ilha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ilha_dp #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .func          (func),
        .request_bytes (request_bytes),
        .block_addr    (block_addr),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_addr   (result_addr),
        .status        (status)
    );

    // a beat taken in moves the sequencer out of idle, so the port closes
    `ILHA_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)
    `ILHA_ASSERT_NOW(a_status_code, out_valid, status != 2'd3)
    `ILHA_ASSERT_NOW(a_addr_aligned, out_valid, result_addr[2:0] == 3'd0)
    `ILHA_ASSERT_NOW(a_fail_no_addr, out_valid && status != ST_DONE, result_addr == 16'd0)

endmodule
`default_nettype wire
